// File: rtl/core/swa_pkg.sv
// swa_pkg: shared constants, payload types, fsm state and control structs
// for the sliding window average block.
// No dependencies; compiled first.
package swa_pkg;

    // window depth and derived widths
    localparam int WINDOW    = 8;
    localparam int LOG_WIN   = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int IDX_W     = (WINDOW > 1) ? LOG_WIN : 1;
    localparam int COUNT_W   = $clog2(WINDOW + 1);
    localparam int SAMPLE_W  = 32;
    localparam int FILL_W    = 4;
    localparam int SUM_W     = SAMPLE_W + LOG_WIN;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // input transaction payload
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } swa_in_t;

    // output transaction payload
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic [FILL_W-1:0]          fill_level;
        logic                       window_full;
    } swa_out_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLACE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } swa_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic append;    // store new sample in next free slot, add to sum
        logic fetch;     // capture sample, read oldest slot
        logic replace;   // swap oldest for new sample, update sum
        logic div_load;  // start division of sum by fill count
        logic div_step;  // one quotient bit
        logic out_load;  // write result into output register
    } swa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic div_last;
    } swa_status_t;

endpackage

// File: rtl/core/swa_if.sv
// swa_if: valid/ready channel interfaces for the input and output sides.
// Depends on swa_pkg for the payload types.
interface swa_in_if;
    logic             valid;
    logic             ready;
    swa_pkg::swa_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swa_out_if;
    logic              valid;
    logic              ready;
    swa_pkg::swa_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/swa_ctrl.sv
// swa_ctrl: controller state machine, sequences window update, division
// and the output register. Depends on swa_pkg.
module swa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  swa_pkg::swa_status_t status,
    output swa_pkg::swa_cmd_t    cmd
);

    swa_pkg::swa_state_t state_reg;
    swa_pkg::swa_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accept;
    logic                out_free;

    assign in_ready  = (state_reg == swa_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.full ? swa_pkg::ST_REPLACE : swa_pkg::ST_LOAD;
                end
            end
            swa_pkg::ST_REPLACE:
            begin
                state_next = swa_pkg::ST_LOAD;
            end
            swa_pkg::ST_LOAD:
            begin
                state_next = swa_pkg::ST_DIV;
            end
            swa_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = swa_pkg::ST_FINISH;
                end
            end
            swa_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = swa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swa_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            swa_pkg::ST_IDLE:
            begin
                cmd.append = accept && !status.full;
                cmd.fetch  = accept && status.full;
            end
            swa_pkg::ST_REPLACE:
            begin
                cmd.replace = 1'b1;
            end
            swa_pkg::ST_LOAD:
            begin
                cmd.div_load = 1'b1;
            end
            swa_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            swa_pkg::ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("swa_ctrl: output register overwritten");

    // an accepted transaction always moves into update or load
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == swa_pkg::ST_REPLACE || state_reg == swa_pkg::ST_LOAD))
        else $error("swa_ctrl: bad state after accept");

    // last division step leads to finish
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swa_pkg::ST_DIV && status.div_last) |=>
            (state_reg == swa_pkg::ST_FINISH))
        else $error("swa_ctrl: division did not finish");

endmodule

// File: rtl/core/swa_dp.sv
// swa_dp: datapath with sample store, ring pointer, fill count, running sum,
// restoring divider and output register. Depends on swa_pkg.
module swa_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [swa_pkg::SAMPLE_W-1:0] in_sample,
    input  swa_pkg::swa_cmd_t            cmd,
    output swa_pkg::swa_status_t         status,
    output swa_pkg::swa_out_t            out_data
);

    localparam int SUM_W   = swa_pkg::SUM_W;
    localparam int COUNT_W = swa_pkg::COUNT_W;
    localparam int IDX_W   = swa_pkg::IDX_W;

    logic signed [swa_pkg::SAMPLE_W-1:0] store_mem [swa_pkg::WINDOW];

    logic signed [swa_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [swa_pkg::SAMPLE_W-1:0] old_reg;
    logic [COUNT_W-1:0]                  count_reg;
    logic [COUNT_W-1:0]                  count_next;
    logic [IDX_W-1:0]                    ptr_reg;
    logic [IDX_W-1:0]                    ptr_next;
    logic signed [SUM_W-1:0]             sum_reg;
    logic signed [SUM_W-1:0]             sum_next;
    logic [SUM_W-1:0]                    qd_reg;
    logic [SUM_W-1:0]                    qd_next;
    logic [COUNT_W-1:0]                  rem_reg;
    logic [COUNT_W-1:0]                  rem_next;
    logic                                neg_reg;
    logic [swa_pkg::DIV_CNT_W-1:0]       div_cnt_reg;
    logic [swa_pkg::DIV_CNT_W-1:0]       div_cnt_next;
    swa_pkg::swa_out_t                   out_reg;

    logic signed [swa_pkg::SAMPLE_W:0]   diff;
    logic [COUNT_W:0]                    rem_shift;
    logic [COUNT_W:0]                    rem_sub;
    logic                                rem_ge;
    logic [SUM_W-1:0]                    sum_mag;
    logic [SUM_W-1:0]                    quot;
    logic                                full;

    assign full = (count_reg == COUNT_W'(swa_pkg::WINDOW));

    // window update arithmetic
    assign diff = (swa_pkg::SAMPLE_W+1)'(sample_reg) - (swa_pkg::SAMPLE_W+1)'(old_reg);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        if (cmd.append)
        begin
            sum_next   = sum_reg + SUM_W'(in_sample);
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.replace)
        begin
            sum_next = sum_reg + SUM_W'(diff);
            ptr_next = (ptr_reg == IDX_W'(swa_pkg::WINDOW - 1)) ? '0 : ptr_reg + IDX_W'(1);
        end
    end

    // one restoring division step, dividend shifted out as quotient shifts in
    assign rem_shift = {rem_reg, qd_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, count_reg});
    assign rem_sub   = rem_shift - {1'b0, count_reg};
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_comb
    begin
        qd_next      = qd_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_load)
        begin
            qd_next      = sum_mag;
            rem_next     = '0;
            div_cnt_next = swa_pkg::DIV_CNT_W'(SUM_W);
        end
        else if (cmd.div_step)
        begin
            qd_next      = {qd_reg[SUM_W-2:0], rem_ge};
            rem_next     = rem_ge ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            div_cnt_next = div_cnt_reg - swa_pkg::DIV_CNT_W'(1);
        end
    end

    // signed quotient, truncated toward zero
    assign quot = neg_reg ? SUM_W'(-qd_reg) : qd_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            sum_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            sum_reg     <= sum_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= in_sample;
        end
        else if (cmd.replace)
        begin
            store_mem[ptr_reg] <= sample_reg;
        end
        if (cmd.fetch)
        begin
            old_reg <= store_mem[ptr_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            sample_reg <= in_sample;
        end
        if (cmd.div_load)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        if (cmd.out_load)
        begin
            out_reg.average     <= quot[swa_pkg::SAMPLE_W-1:0];
            out_reg.fill_level  <= swa_pkg::FILL_W'(count_reg);
            out_reg.window_full <= full;
        end
    end

    assign status.full     = full;
    assign status.div_last = (div_cnt_reg == swa_pkg::DIV_CNT_W'(1));
    assign out_data        = out_reg;

    // fill count saturates at the window depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(swa_pkg::WINDOW))
        else $error("swa_dp: fill count beyond window");

    // the sample store is only appended to while filling
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !full)
        else $error("swa_dp: append into full window");

    // a division step always has steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (div_cnt_reg != '0))
        else $error("swa_dp: division step with no bits left");

endmodule

// File: rtl/core/sliding_window_average.sv
// channel   dir  payload                                 role
// feed      in   sample                                  one Q16.16 sample per transaction
// result    out  average, fill_level, window_full        one result per input transaction
//
// A transaction runs from acceptance via REPLACE (once the window is full), LOAD,
// DIV and FINISH, which waits for a free output register, to the next acceptance.
// The bit-serial divider makes one quotient bit per cycle over the 35-bit running sum.
// Reset (rst_n, asynchronous) empties the window; the store itself is not cleared.
// A finished result waits in the output register while the next sample is taken;
// the divider holds its answer only if that register is still occupied.
// Top level: joins swa_ctrl and swa_dp; depends on swa_pkg and swa_if.
module sliding_window_average (
    input  logic   clk,
    input  logic   rst_n,
    swa_in_if.sink     feed,
    swa_out_if.source  result
);

    swa_pkg::swa_cmd_t    cmd;
    swa_pkg::swa_status_t status;
    logic                 in_ready;
    logic                 out_valid;

    swa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (feed.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    swa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_sample (feed.data.sample),
        .cmd       (cmd),
        .status    (status),
        .out_data  (result.data)
    );

    assign feed.ready   = in_ready;
    assign result.valid = out_valid;

endmodule
